>>> hw/rtl/prww_pkg.sv
package prww_pkg;

  // default number of pages in the backing store
  localparam int unsigned PAGE_COUNT = 16;

  // page geometry: high address byte is the page, low byte the offset
  localparam int unsigned PAGE_BYTES = 256;
  localparam int unsigned OFFSET_W   = 8;
  localparam int unsigned PAGE_W     = 8;
  localparam int unsigned ADDR_W     = PAGE_W + OFFSET_W;
  localparam int unsigned DATA_W     = 8;
  localparam int unsigned WEAR_W     = 32;

  localparam logic [WEAR_W-1:0] WEAR_MAX = {WEAR_W{1'b1}};

  // access kinds
  typedef enum logic {
    FUNC_READ  = 1'b0,
    FUNC_WRITE = 1'b1
  } func_e;

  // saturating increment of a wear counter
  function automatic logic [WEAR_W-1:0] wear_bump(logic [WEAR_W-1:0] v);
    logic [WEAR_W-1:0] r;
    r = (v == WEAR_MAX) ? v : v + WEAR_W'(1);
    return r;
  endfunction

endpackage

>>> hw/rtl/prww_if.sv
// access request channel
interface prww_req_if;
  logic                          valid;
  logic                          ready;
  logic                          func;
  logic [prww_pkg::ADDR_W-1:0]   address;
  logic [prww_pkg::DATA_W-1:0]   write_data;

  modport source (output valid, output func, output address, output write_data,
                  input ready);
  modport sink   (input valid, input func, input address, input write_data,
                  output ready);
endinterface

// access result channel
interface prww_rsp_if;
  logic                          valid;
  logic                          ready;
  logic [prww_pkg::DATA_W-1:0]   read_data;
  logic                          out_of_range;
  logic                          page_swapped;
  logic [prww_pkg::WEAR_W-1:0]   fetch_count;
  logic [prww_pkg::WEAR_W-1:0]   writeback_count;

  modport source (output valid, output read_data, output out_of_range,
                  output page_swapped, output fetch_count, output writeback_count,
                  input ready);
  modport sink   (input valid, input read_data, input out_of_range,
                  input page_swapped, input fetch_count, input writeback_count,
                  output ready);
endinterface

>>> hw/rtl/paged_ram_window_writeback.sv
// channel  dir  fields
// -------  ---  ---------------------------------------------------------------
// req_i    in   func, address, write_data
// rsp_o    out  read_data, out_of_range, page_swapped, fetch_count,
//               writeback_count
//
// A new access enters only once the previous one has left the read stage.
// The access cycle reads or writes the byte memory and registers the read
// data; the move to the output register takes it into the result. After
// reset a clearing pass zeroes all PageCount*256 bytes, one byte a cycle;
// req_i.ready stays low until it ends. The output register lets a new access
// enter while a result waits; a stalled rsp_o holds it in the read stage.
// The resident page buffer is write-back transparent, so its bytes live in
// the same memory as the store; only the resident page and dirty flag are
// tracked, which decide the swap flag and the wear counters.
module paged_ram_window_writeback #(
  parameter int unsigned PageCount = prww_pkg::PAGE_COUNT
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  prww_req_if.sink       req_i,
  prww_rsp_if.source     rsp_o
);

  localparam int unsigned Depth = PageCount * prww_pkg::PAGE_BYTES;
  localparam int unsigned MemAw = $clog2(Depth);
  localparam int unsigned PageCmpW = prww_pkg::PAGE_W + 1;

  // byte memory holding every in-range page of the virtual space
  logic [prww_pkg::DATA_W-1:0] mem_q [Depth];
  logic [prww_pkg::DATA_W-1:0] mem_rd_q;

  // clearing pass
  logic             clr_q;
  logic [MemAw-1:0] clr_addr_q;

  // page tracking and wear
  logic [prww_pkg::PAGE_W-1:0] resident_q, resident_d;
  logic                        dirty_q, dirty_d;
  logic [prww_pkg::WEAR_W-1:0] fetch_q, fetch_d;
  logic [prww_pkg::WEAR_W-1:0] wb_q, wb_d;

  // read stage
  logic                        pend_q;
  logic                        pend_rd_q;
  logic                        pend_oor_q;
  logic                        pend_swap_q;
  logic [prww_pkg::WEAR_W-1:0] pend_fetch_q;
  logic [prww_pkg::WEAR_W-1:0] pend_wb_q;

  // output register
  logic                        out_vld_q;
  logic [prww_pkg::DATA_W-1:0] out_data_q;
  logic                        out_oor_q;
  logic                        out_swap_q;
  logic [prww_pkg::WEAR_W-1:0] out_fetch_q;
  logic [prww_pkg::WEAR_W-1:0] out_wb_q;

  logic                        acc;
  logic                        move;
  logic                        oor;
  logic                        swap;
  logic                        is_wr;
  logic [prww_pkg::PAGE_W-1:0] page;
  logic [MemAw-1:0]            acc_addr;
  logic                        mem_we;
  logic [MemAw-1:0]            mem_wa;
  logic [prww_pkg::DATA_W-1:0] mem_wd;

  // handshakes
  assign req_i.ready = !clr_q && !pend_q;
  assign acc         = req_i.valid && req_i.ready;
  assign move        = pend_q && (!out_vld_q || rsp_o.ready);

  // access decode
  assign page     = req_i.address[prww_pkg::ADDR_W-1:prww_pkg::OFFSET_W];
  assign oor      = PageCmpW'(page) >= PageCmpW'(PageCount);
  assign swap     = !oor && (page != resident_q);
  assign is_wr    = req_i.func == prww_pkg::FUNC_WRITE;
  assign acc_addr = req_i.address[MemAw-1:0];

  // page, dirty and wear updates
  always_comb begin
    resident_d = resident_q;
    dirty_d    = dirty_q;
    fetch_d    = fetch_q;
    wb_d       = wb_q;
    if (acc && !oor) begin
      if (swap) begin
        resident_d = page;
        fetch_d    = prww_pkg::wear_bump(fetch_q);
        if (dirty_q) begin
          wb_d = prww_pkg::wear_bump(wb_q);
        end
        dirty_d = is_wr;
      end else if (is_wr) begin
        dirty_d = 1'b1;
      end
    end
  end

  // memory write port: clearing pass or accepted write
  always_comb begin
    mem_we = 1'b0;
    mem_wa = acc_addr;
    mem_wd = req_i.write_data;
    if (clr_q) begin
      mem_we = 1'b1;
      mem_wa = clr_addr_q;
      mem_wd = '0;
    end else if (acc && !oor && is_wr) begin
      mem_we = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_wa] <= mem_wd;
    end
    if (acc) begin
      mem_rd_q <= mem_q[acc_addr];
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q      <= 1'b1;
      clr_addr_q <= '0;
      resident_q <= '0;
      dirty_q    <= 1'b0;
      fetch_q    <= '0;
      wb_q       <= '0;
      pend_q     <= 1'b0;
      out_vld_q  <= 1'b0;
    end else begin
      if (clr_q) begin
        clr_addr_q <= clr_addr_q + MemAw'(1);
        if (clr_addr_q == MemAw'(Depth - 1)) begin
          clr_q <= 1'b0;
        end
      end
      resident_q <= resident_d;
      dirty_q    <= dirty_d;
      fetch_q    <= fetch_d;
      wb_q       <= wb_d;
      if (acc) begin
        pend_q <= 1'b1;
      end else if (move) begin
        pend_q <= 1'b0;
      end
      if (move) begin
        out_vld_q <= 1'b1;
      end else if (rsp_o.ready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  // read stage and output payload
  always_ff @(posedge clk_i) begin
    if (acc) begin
      pend_rd_q    <= !oor && !is_wr;
      pend_oor_q   <= oor;
      pend_swap_q  <= swap;
      pend_fetch_q <= fetch_d;
      pend_wb_q    <= wb_d;
    end
    if (move) begin
      out_data_q  <= pend_rd_q ? mem_rd_q : '0;
      out_oor_q   <= pend_oor_q;
      out_swap_q  <= pend_swap_q;
      out_fetch_q <= pend_fetch_q;
      out_wb_q    <= pend_wb_q;
    end
  end

  assign rsp_o.valid           = out_vld_q;
  assign rsp_o.read_data       = out_data_q;
  assign rsp_o.out_of_range    = out_oor_q;
  assign rsp_o.page_swapped    = out_swap_q;
  assign rsp_o.fetch_count     = out_fetch_q;
  assign rsp_o.writeback_count = out_wb_q;

endmodule
